@@ design/psgu_pkg.sv @@
// ----------------------------------------------------------------------------
// psgu_pkg
// Shared types and constants for the phase-shift / gray-code unwrap block.
// ----------------------------------------------------------------------------
package psgu_pkg;

	localparam int PHASE_BITS    = 16;
	localparam int MAX_CODE_BITS = 7;
	localparam int CORDIC_STEPS  = 32;
	localparam int GRAY_SAMPLES  = 7;
	localparam int SAMPLE_W      = 8;
	localparam int ANGLE_W       = 32;
	// CORDIC datapath width: |v| * gain * 2^32 stays below 2^42, plus sign
	localparam int XW            = 44;

	localparam int IN_TDATA_W    = (4 + GRAY_SAMPLES) * SAMPLE_W;
	localparam int UNWRAP_W      = MAX_CODE_BITS + PHASE_BITS;
	localparam int OUT_FIELDS_W  = PHASE_BITS + MAX_CODE_BITS + UNWRAP_W;
	localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 8;
	localparam int CODE_BITS_W   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_GRAY_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS      = 1'd1;

	localparam logic [CFG_DATA_W-1:0]  GRAY_THRESHOLD_RST = 8'd130;
	localparam logic [CODE_BITS_W-1:0] CODE_BITS_RST      = 3'd7;
	localparam logic [CODE_BITS_W-1:0] CODE_SIX           = 3'd6;
	localparam logic [CODE_BITS_W-1:0] CODE_SEVEN         = 3'd7;
	localparam logic [CODE_BITS_W-1:0] CODE_MAX           = CODE_BITS_W'(MAX_CODE_BITS);

	localparam logic [ANGLE_W-1:0] HALF_TURN   = 32'h8000_0000;
	localparam logic [ANGLE_W-1:0] ROUND_CONST = ANGLE_W'(1) << (ANGLE_W - 1 - PHASE_BITS);

	// atan(2^-i) in turns, scaled by 2^32
	localparam logic [ANGLE_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	// classified pixel handed from front to back
	typedef struct packed {
		logic [SAMPLE_W-1:0]      dx;      // |shift1 - shift3|
		logic [SAMPLE_W:0]        dy;      // signed, sign-fixed with dx
		logic                     half;    // vector was folded by a half turn
		logic                     zero;    // both differences zero
		logic [MAX_CODE_BITS-1:0] idx;     // decoded period index
	} psgu_item_t;

	localparam int ITEM_W = $bits(psgu_item_t);

endpackage

@@ design/psgu_front.sv @@
// ----------------------------------------------------------------------------
// psgu_front
// Config registers, input beat classification and gray-code decoding.
// ----------------------------------------------------------------------------
module psgu_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [psgu_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psgu_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [psgu_pkg::IN_TDATA_W-1:0]     s_tdata,
	output psgu_pkg::psgu_item_t                item
);
	import psgu_pkg::*;

	logic [CFG_DATA_W-1:0]    thr_q;
	logic [CODE_BITS_W-1:0]   code_q;
	logic [SAMPLE_W-1:0]      sh0, sh1, sh2, sh3;
	logic signed [SAMPLE_W:0] dx_raw, dy_raw, dx_neg, dy_neg;
	logic [MAX_CODE_BITS-1:0] pre;
	logic [MAX_CODE_BITS-1:0] idx_full, idx_short, idx_sel;
	logic                     use_full, use_short;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= GRAY_THRESHOLD_RST;
			code_q <= CODE_BITS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRAY_THRESHOLD: thr_q  <= cfg_data;
				REG_CODE_BITS:      code_q <= cfg_data[CODE_BITS_W-1:0];
				default:            ;
			endcase
		end
	end

	// phase differences, folded into the right half plane
	always_comb begin
		sh0    = s_tdata[0*SAMPLE_W +: SAMPLE_W];
		sh1    = s_tdata[1*SAMPLE_W +: SAMPLE_W];
		sh2    = s_tdata[2*SAMPLE_W +: SAMPLE_W];
		sh3    = s_tdata[3*SAMPLE_W +: SAMPLE_W];
		dx_raw = $signed({1'b0, sh1}) - $signed({1'b0, sh3});
		dy_raw = $signed({1'b0, sh0}) - $signed({1'b0, sh2});
		dx_neg = -dx_raw;
		dy_neg = -dy_raw;
		item.half = dx_raw[SAMPLE_W];
		item.zero = (dx_raw == '0) && (dy_raw == '0);
		item.dx   = item.half ? dx_neg[SAMPLE_W-1:0] : dx_raw[SAMPLE_W-1:0];
		item.dy   = item.half ? dy_neg : dy_raw;
		item.idx  = idx_sel;
	end

	// threshold and gray-to-binary prefix XOR, MSB first
	always_comb begin
		pre[0] = s_tdata[4*SAMPLE_W +: SAMPLE_W] > thr_q;
		for (int k = 1; k < MAX_CODE_BITS; k++) begin
			pre[k] = pre[k-1] ^ (s_tdata[(4+k)*SAMPLE_W +: SAMPLE_W] > thr_q);
		end
		for (int j = 0; j < MAX_CODE_BITS; j++) begin
			idx_full[j] = pre[MAX_CODE_BITS-1-j];
		end
		// six bits: the seventh sample's bit drops out at the bottom
		idx_short = {1'b0, idx_full[MAX_CODE_BITS-1:1]};
		use_full  = (code_q == CODE_MAX) || (code_q == CODE_SEVEN);
		use_short = (code_q == CODE_SIX) && !use_full;
		idx_sel   = use_full ? idx_full : (use_short ? idx_short : '0);
	end

endmodule

@@ design/psgu_queue.sv @@
// ----------------------------------------------------------------------------
// psgu_queue
// Four-entry FIFO decoupling the classifier from the CORDIC pipeline.
// ----------------------------------------------------------------------------
module psgu_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  psgu_pkg::psgu_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output psgu_pkg::psgu_item_t head,
	output logic                 empty
);
	import psgu_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = 2;

	psgu_item_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/psgu_back.sv @@
// ----------------------------------------------------------------------------
// psgu_back
// Unrolled vectoring CORDIC, one stage per iteration, plus output register.
// ----------------------------------------------------------------------------
module psgu_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  psgu_pkg::psgu_item_t               head,
	input  logic                               empty,
	output logic                               pop,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [psgu_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import psgu_pkg::*;

	logic signed [XW-1:0]     x_s   [CORDIC_STEPS+1];
	logic signed [XW-1:0]     y_s   [CORDIC_STEPS+1];
	logic [ANGLE_W-1:0]       z_s   [CORDIC_STEPS+1];
	logic [MAX_CODE_BITS-1:0] idx_s [CORDIC_STEPS+1];
	logic                     zero_s[CORDIC_STEPS+1];
	logic                     v_s   [CORDIC_STEPS+1];

	logic                     out_v_q;
	logic [PHASE_BITS-1:0]    phase_q;
	logic [MAX_CODE_BITS-1:0] idx_q;
	logic                     adv;
	logic [ANGLE_W-1:0]       z_rnd;

	// whole pipeline moves unless the output beat is held
	assign adv = !out_v_q || m_tready;
	assign pop = adv && !empty;

	// stage 0 load
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0]    <= {{(XW-SAMPLE_W-ANGLE_W){1'b0}}, head.dx, {ANGLE_W{1'b0}}};
			y_s[0]    <= {{(XW-SAMPLE_W-1-ANGLE_W){head.dy[SAMPLE_W]}}, head.dy,
			              {ANGLE_W{1'b0}}};
			z_s[0]    <= head.half ? HALF_TURN : '0;
			idx_s[0]  <= head.idx;
			zero_s[0] <= head.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= !empty;
		end
	end

	// one micro-rotation per stage
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
		logic signed [XW-1:0] xs, ys;
		logic                 pos;

		assign xs  = x_s[k] >>> k;
		assign ys  = y_s[k] >>> k;
		assign pos = y_s[k] > 0;

		always_ff @(posedge clk) begin
			if (adv) begin
				x_s[k+1]    <= pos ? x_s[k] + ys : x_s[k] - ys;
				y_s[k+1]    <= pos ? y_s[k] - xs : y_s[k] + xs;
				z_s[k+1]    <= pos ? z_s[k] + ATAN_TURN[k] : z_s[k] - ATAN_TURN[k];
				idx_s[k+1]  <= idx_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end
	end

	// round to PHASE_BITS, full turn wraps to zero
	assign z_rnd = z_s[CORDIC_STEPS] + ROUND_CONST;

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_q <= zero_s[CORDIC_STEPS] ? '0 : z_rnd[ANGLE_W-1 -: PHASE_BITS];
			idx_q   <= idx_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s[CORDIC_STEPS];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}}, idx_q, phase_q, idx_q, phase_q};

endmodule

@@ design/phase_shift_gray_code_unwrap_top.sv @@
// Path from an accepted input beat to its output beat: the queue register,
// 33 CORDIC stages, output register. Throughput: one pixel per cycle
// while the output is not stalled, set by the fully unrolled 32-step CORDIC.
// A four-entry queue sits between classifier and CORDIC pipeline.
// Reset (arst_n low, async): pipeline and queue empty, gray_threshold = 130,
// code_bits = 7.
// ----------------------------------------------------------------------------
// phase_shift_gray_code_unwrap_top
// Four-step phase-shift wrapped phase plus gray-code period, unwrapped phase.
// ----------------------------------------------------------------------------
module phase_shift_gray_code_unwrap_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [psgu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [psgu_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// shift0, shift1, shift2, shift3, gray0 .. gray6 (8 bits each, from bit 0)
	input  logic [psgu_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// wrapped_phase[15:0], period_index[22:16], unwrapped_phase[45:23], zero pad
	output logic [psgu_pkg::OUT_TDATA_W-1:0]  m_tdata
);
	import psgu_pkg::*;

	psgu_item_t item, head;
	logic       full, empty, pop, push;

	assign s_tready = !full;
	assign push     = s_tvalid && !full;

	psgu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.item      (item)
	);

	psgu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (item),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	psgu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ test/unwrap_checker.sv @@
// ----------------------------------------------------------------------------
// unwrap_checker
// Passive checker for the phase-shift / gray-code unwrap block. It tracks the
// register writes, predicts each pixel's wrapped phase (bit-true CORDIC in
// turns) and period index, queues them in order and compares every output
// beat field by field. The wrapped phase may differ by one LSB either way.
// ----------------------------------------------------------------------------
module unwrap_checker
	import psgu_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     fail_count,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PHASE_BITS-1:0]    phase;
		logic [MAX_CODE_BITS-1:0] idx;
	} pixel_result_t;

	pixel_result_t             pixel_q[$];
	logic [CFG_DATA_W-1:0]     thr_copy;
	logic [CODE_BITS_W-1:0]    code_bits_copy;

	// Vectoring CORDIC on (dx, dy), angle kept as a 32-bit fraction of a turn
	function automatic logic [PHASE_BITS-1:0] cordic_phase(input int dx_in, input int dy_in);
		longint             x;
		longint             y;
		longint             xs;
		longint             ys;
		int                 dx;
		int                 dy;
		logic [ANGLE_W-1:0] z;
		logic [ANGLE_W:0]   rounded;
		dx = dx_in;
		dy = dy_in;
		z  = '0;
		if (dx == 0 && dy == 0)
			return '0;
		// fold the left half-plane onto the right one
		if (dx < 0) begin
			dx = -dx;
			dy = -dy;
			z  = HALF_TURN;
		end
		x = longint'(dx) * 64'sd4294967296;
		y = longint'(dy) * 64'sd4294967296;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TURN[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TURN[i];
			end
		end
		// round to nearest; a carry out of the top wraps to zero
		rounded = {1'b0, z} + {1'b0, ROUND_CONST};
		return rounded[ANGLE_W-1 -: PHASE_BITS];
	endfunction

	// Threshold the gray samples and XOR-chain them to binary, MSB first
	function automatic logic [MAX_CODE_BITS-1:0] gray_to_period(
		input logic [GRAY_SAMPLES*SAMPLE_W-1:0] gray,
		input logic [CFG_DATA_W-1:0]            thr,
		input logic [CODE_BITS_W-1:0]           nbits
	);
		int                       n;
		logic                     bin;
		logic [MAX_CODE_BITS-1:0] idx;
		n   = 0;
		bin = 1'b0;
		idx = '0;
		if (nbits == CODE_SIX || nbits == CODE_SEVEN)
			n = (int'(nbits) > MAX_CODE_BITS) ? MAX_CODE_BITS : int'(nbits);
		for (int k = 0; k < n; k++) begin
			bin = bin ^ (gray[k*SAMPLE_W +: SAMPLE_W] > thr);
			idx = {idx[MAX_CODE_BITS-2:0], bin};
		end
		return idx;
	endfunction

	// Compare one output beat against the oldest prediction
	task automatic check_beat(input logic [OUT_TDATA_W-1:0] beat);
		pixel_result_t            want;
		logic [PHASE_BITS-1:0]    got_phase;
		logic [PHASE_BITS-1:0]    phase_err;
		logic [MAX_CODE_BITS-1:0] got_idx;
		logic [UNWRAP_W-1:0]      got_unwrap;
		logic [UNWRAP_W-1:0]      want_unwrap;
		got_phase  = beat[PHASE_BITS-1:0];
		got_idx    = beat[PHASE_BITS +: MAX_CODE_BITS];
		got_unwrap = beat[PHASE_BITS+MAX_CODE_BITS +: UNWRAP_W];
		if (pixel_q.size() == 0) begin
			$display("%0t: unexpected output beat, expected none, got %h", $time, beat);
			fail_count++;
			return;
		end
		want = pixel_q.pop_front();
		// one LSB of rounding slack, modulo a full turn
		phase_err = got_phase - want.phase;
		if (phase_err != 0 && phase_err != 1 && phase_err != '1) begin
			$display("%0t: wrapped_phase expected %0d, got %0d", $time, want.phase, got_phase);
			fail_count++;
		end
		if (got_idx !== want.idx) begin
			$display("%0t: period_index expected %0d, got %0d", $time, want.idx, got_idx);
			fail_count++;
		end
		want_unwrap = {want.idx, got_phase};
		if (got_unwrap !== want_unwrap) begin
			$display("%0t: unwrapped_phase expected %0d, got %0d", $time, want_unwrap,
				got_unwrap);
			fail_count++;
		end
		if (beat[OUT_TDATA_W-1:OUT_FIELDS_W] !== '0) begin
			$display("%0t: tdata pad expected 0, got %h", $time,
				beat[OUT_TDATA_W-1:OUT_FIELDS_W]);
			fail_count++;
		end
	endtask

	// Register copy, output check, then prediction of the newly accepted pixel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_copy       <= GRAY_THRESHOLD_RST;
			code_bits_copy <= CODE_BITS_RST;
			pixel_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_GRAY_THRESHOLD)
					thr_copy <= cfg_data;
				else if (cfg_index == REG_CODE_BITS)
					code_bits_copy <= cfg_data[CODE_BITS_W-1:0];
			end
			if (m_tvalid && m_tready)
				check_beat(m_tdata);
			if (s_tvalid && s_tready)
				pixel_q.push_back('{
					phase: cordic_phase(int'(s_tdata[15:8]) - int'(s_tdata[31:24]),
						int'(s_tdata[7:0]) - int'(s_tdata[23:16])),
					idx:   gray_to_period(s_tdata[IN_TDATA_W-1:4*SAMPLE_W], thr_copy,
						code_bits_copy)
				});
			pending = pixel_q.size();
		end
	end

endmodule

@@ test/tb_phase_shift_gray_code_unwrap_top.sv @@
// ----------------------------------------------------------------------------
// tb_phase_shift_gray_code_unwrap_top
// Stimulus and verdict for the phase-shift / gray-code unwrap block. Directed
// pixels cover the axes, octants, zero vector and gray thresholds; random
// pixels follow under several threshold / code-width settings, with random
// gaps on both stream sides. Checking is done by unwrap_checker.
// ----------------------------------------------------------------------------
module tb_phase_shift_gray_code_unwrap_top;
	timeunit 1ns;
	timeprecision 1ps;

	import psgu_pkg::*;

	localparam int IDLE_LIMIT    = 1000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int RANDOM_PIXELS = 160;
	localparam int PHASES        = 10;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int                     fail_count;
	int                     pending;
	int                     idle_cycles = 0;
	bit                     steady = 1'b0;
	logic [CFG_DATA_W-1:0]  cur_thr = GRAY_THRESHOLD_RST;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	phase_shift_gray_code_unwrap_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	unwrap_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// Gap in cycles before the next beat on either side
	function automatic int gap_cycles();
		return steady ? 0 : $urandom_range(0, 10);
	endfunction

	// Pack one pixel: shift0 in the low byte, gray6 in the top byte
	function automatic logic [IN_TDATA_W-1:0] px(
		input logic [7:0] s0, input logic [7:0] s1, input logic [7:0] s2,
		input logic [7:0] s3, input logic [GRAY_SAMPLES*SAMPLE_W-1:0] gray
	);
		return {gray, s3, s2, s1, s0};
	endfunction

	// Random pixel, biased toward gray values at the threshold, equal shift
	// pairs (phase on an axis) and tiny difference vectors
	function automatic logic [IN_TDATA_W-1:0] rand_pixel(input logic [7:0] thr);
		logic [7:0]            b[11];
		logic [7:0]            base;
		logic [IN_TDATA_W-1:0] r;
		for (int i = 0; i < 11; i++)
			b[i] = 8'($urandom);
		case ($urandom_range(0, 9))
			4, 5: begin
				for (int k = 4; k < 11; k++)
					case ($urandom_range(0, 4))
						0: b[k] = thr - 8'd1;
						1: b[k] = thr;
						2: b[k] = thr + 8'd1;
						3: b[k] = 8'd0;
						default: b[k] = 8'd255;
					endcase
			end
			6, 7: begin
				case ($urandom_range(0, 2))
					0: b[2] = b[0];
					1: b[3] = b[1];
					default: begin
						b[2] = b[0];
						b[3] = b[1];
					end
				endcase
			end
			8, 9: begin
				base = 8'($urandom);
				for (int i = 0; i < 4; i++)
					b[i] = base + 8'($urandom_range(0, 6)) - 8'd3;
			end
			default: ;
		endcase
		for (int i = 0; i < 11; i++)
			r[8*i +: 8] = b[i];
		return r;
	endfunction

	// Offer one pixel after a random gap and hold it until accepted
	task automatic send_pixel(input logic [IN_TDATA_W-1:0] pix);
		int n;
		n = gap_cycles();
		repeat (n) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= pix;
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending and wait for every predicted beat to come out
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Threshold edges and the top gray sample alone under the current setting
	task automatic threshold_edges();
		send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0, {GRAY_SAMPLES{cur_thr}}));
		send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0, {GRAY_SAMPLES{cur_thr + 8'd1}}));
		send_pixel(px(8'd255, 8'd0, 8'd255, 8'd0, {8'hFF, 48'h0}));
		send_pixel(px(8'd3, 8'd7, 8'd5, 8'd2, {GRAY_SAMPLES{8'hFF}}));
	endtask

	// Sink: random stall before each beat, none while steady
	initial begin
		int n;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = gap_cycles();
			repeat (n) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	// Watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus
	initial begin
		logic [CFG_DATA_W-1:0] thr_set[PHASES];
		logic [CODE_BITS_W-1:0] cb_set[PHASES];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		thr_set   = '{8'd0, 8'd255, 8'd1, 8'd254, 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom), 8'($urandom), GRAY_THRESHOLD_RST};
		cb_set    = '{CODE_SEVEN, CODE_SIX, CODE_SEVEN, CODE_SIX, 3'd0, 3'd5,
			CODE_SEVEN, CODE_SIX, 3'($urandom_range(0, 7)), CODE_SEVEN};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed pixels under the reset settings
		send_pixel(px(8'd0, 8'd0, 8'd0, 8'd0, '0));
		send_pixel(px(8'd255, 8'd255, 8'd255, 8'd255, {GRAY_SAMPLES{8'hFF}}));
		send_pixel(px(8'd0, 8'd255, 8'd0, 8'd0, {48'h0, 8'hFF}));
		send_pixel(px(8'd0, 8'd0, 8'd0, 8'd255, {8'hFF, 48'h0}));
		send_pixel(px(8'd255, 8'd0, 8'd0, 8'd0, {GRAY_SAMPLES{8'd130}}));
		send_pixel(px(8'd0, 8'd0, 8'd255, 8'd0, {GRAY_SAMPLES{8'd131}}));
		send_pixel(px(8'd255, 8'd255, 8'd0, 8'd0, 56'hFF00FF00FF00FF));
		send_pixel(px(8'd0, 8'd0, 8'd255, 8'd255, 56'h00FF00FF00FF00));
		send_pixel(px(8'd0, 8'd255, 8'd255, 8'd0, 56'h01020304050607));
		send_pixel(px(8'd255, 8'd0, 8'd0, 8'd255, 56'h8283848586878F));
		send_pixel(px(8'd0, 8'd255, 8'd1, 8'd0, '0));
		send_pixel(px(8'd1, 8'd0, 8'd0, 8'd255, '0));
		send_pixel(px(8'd0, 8'd0, 8'd1, 8'd255, '0));
		send_pixel(px(8'd128, 8'd1, 8'd127, 8'd0, '0));
		send_pixel(px(8'd0, 8'd1, 8'd0, 8'd0, '0));
		send_pixel(px(8'd0, 8'd0, 8'd0, 8'd1, '0));
		send_pixel(px(8'd1, 8'd0, 8'd0, 8'd0, '0));
		send_pixel(px(8'd0, 8'd0, 8'd1, 8'd0, '0));
		for (int i = 0; i < 200; i++) begin
			steady = (i < 40);
			send_pixel(rand_pixel(cur_thr));
		end

		// one phase per register setting, written with the pipe empty
		for (int ph = 0; ph < PHASES; ph++) begin
			steady = 1'b0;
			drain();
			write_reg(REG_GRAY_THRESHOLD, thr_set[ph]);
			write_reg(REG_CODE_BITS, CFG_DATA_W'(cb_set[ph]));
			cur_thr = thr_set[ph];
			threshold_edges();
			for (int i = 0; i < RANDOM_PIXELS; i++) begin
				steady = (ph % 2 == 1) && (i < 40);
				send_pixel(rand_pixel(cur_thr));
			end
		end

		steady = 1'b0;
		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
